// ===== rtl/core/modulo_hashed_record_table_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the modulo hashed record table
// Shared forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef MODULO_HASHED_RECORD_TABLE_TOP_ASSERT_SVH
`define MODULO_HASHED_RECORD_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked on every clock edge outside reset
`define MHT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MHT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mht_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mht_pkg
// Field widths, operation codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package mht_pkg;

   localparam int MODE_W     = 3;
   localparam int KEY_W      = 31;
   localparam int PAY_W      = 64;
   localparam int SIZE_W     = 11;
   localparam int CNT_W      = $clog2(KEY_W);
   localparam int DATA_W     = 96;   // key + payload, padded to whole bytes

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1021;

   typedef logic [MODE_W-1:0] mode_type;

   localparam mode_type MODE_INSERT = 3'd0;
   localparam mode_type MODE_LOOKUP = 3'd1;
   localparam mode_type MODE_REMOVE = 3'd2;
   localparam mode_type MODE_CLEAR  = 3'd3;
   localparam mode_type MODE_UPDATE = 3'd4;

   // controller -> datapath
   typedef struct packed {
      logic latch;      // capture request word, reset divider and sweep
      logic div_step;   // one restoring-divide step
      logic mem_read;   // read both stores at the hashed slot
      logic exec;       // apply operation, form result
      logic sweep;      // clear one key slot per cycle
      logic init;       // sweep covers the whole depth (post-reset)
      logic load_rsp;   // move result into output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_clear;
      logic div_last;
      logic sweep_last;
      logic init_last;
   } stat_type;

endpackage
`default_nettype wire

// ===== rtl/core/mht_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mht_ctrl
// Sequencer for one operation at a time; owns the result valid flag.
// ---------------------------------------------------------------------------
module mht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output mht_pkg::cmd_type  cmd,
   input  mht_pkg::stat_type stat
);

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_DIV,
      ST_READ,
      ST_EXEC,
      ST_SWEEP,
      ST_SWEEP_END,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
            cmd.init  = 1'b1;
            if (stat.init_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = stat.is_clear ? ST_SWEEP : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = ST_READ;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_RESP;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) state_in = ST_SWEEP_END;
         end
         ST_SWEEP_END: begin
            // last swept key lands in the read register here
            state_in = ST_EXEC;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/core/mht_dpath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mht_dpath
// Key/payload stores, bit-serial modulo unit, sweep counter, result regs.
// ---------------------------------------------------------------------------
module mht_dpath #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mht_pkg::cmd_type             cmd,
   output mht_pkg::stat_type            stat,
   input  logic [mht_pkg::SIZE_W-1:0]   csr_size,
   input  mht_pkg::mode_type            req_mode,
   input  logic [mht_pkg::KEY_W-1:0]    req_key,
   input  logic [mht_pkg::PAY_W-1:0]    req_payload,
   output logic                         rsp_status,
   output logic [mht_pkg::KEY_W-1:0]    rsp_key,
   output logic [mht_pkg::PAY_W-1:0]    rsp_payload
);

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int ES_W = $clog2(TABLE_DEPTH + 1);

   // request word
   mht_pkg::mode_type             mode_ff;
   logic [mht_pkg::KEY_W-1:0]     key_ff;
   logic [mht_pkg::PAY_W-1:0]     pay_ff;

   // effective modulus: zero acts as one, saturates at the depth
   logic [31:0]     size_wide;
   logic [ES_W-1:0] eff_size;

   always_comb begin
      size_wide = 32'(csr_size);
      if (size_wide == 32'd0) size_wide = 32'd1;
      if (size_wide > 32'(TABLE_DEPTH)) size_wide = 32'(TABLE_DEPTH);
      eff_size = size_wide[ES_W-1:0];
   end

   // restoring divider, one key bit per cycle, MSB first
   logic [ES_W-1:0]               rem_ff, rem_in;
   logic [mht_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ES_W:0]                 trial, diff;
   logic [AW-1:0]                 slot;

   always_comb begin
      trial = {rem_ff, key_ff[cnt_ff]};
      diff  = trial - {1'b0, eff_size};
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (cmd.latch) begin
         rem_in = '0;
         cnt_in = mht_pkg::CNT_W'(mht_pkg::KEY_W - 1);
      end else if (cmd.div_step) begin
         rem_in = (trial >= {1'b0, eff_size}) ? diff[ES_W-1:0] : trial[ES_W-1:0];
         cnt_in = cnt_ff - mht_pkg::CNT_W'(1);
      end
   end

   assign slot = rem_ff[AW-1:0];

   // sweep counter and occupancy accumulator
   logic [AW-1:0] sw_ff, sw_in;
   logic          sweep_rd_ff, sweep_rd_in;
   logic          any_ff, any_in;
   logic          sweep_last, init_last;
   logic [mht_pkg::KEY_W-1:0] key_rd_ff;
   logic [mht_pkg::PAY_W-1:0] pay_rd_ff;

   assign sweep_last = (ES_W'(sw_ff) == eff_size - ES_W'(1));
   assign init_last  = (sw_ff == AW'(TABLE_DEPTH - 1));

   always_comb begin
      sw_in = sw_ff;
      if (cmd.latch) begin
         sw_in = '0;
      end else if (cmd.sweep && !(cmd.init ? init_last : sweep_last)) begin
         sw_in = sw_ff + AW'(1);
      end
      sweep_rd_in = cmd.sweep && !cmd.init;
      any_in      = cmd.latch ? 1'b0
                  : (any_ff || (sweep_rd_ff && (key_rd_ff != '0)));
   end

   // operation
   logic                      hit, wr_key, wr_pay;
   logic [mht_pkg::KEY_W-1:0] new_key;
   logic [mht_pkg::PAY_W-1:0] new_pay;
   logic                      res_status_in;
   logic [mht_pkg::KEY_W-1:0] res_key_in;
   logic [mht_pkg::PAY_W-1:0] res_pay_in;

   always_comb begin
      hit           = (key_rd_ff != '0) && (key_rd_ff == key_ff);
      wr_key        = 1'b0;
      wr_pay        = 1'b0;
      new_key       = key_ff;
      new_pay       = pay_ff;
      res_status_in = 1'b1;
      res_key_in    = '0;
      res_pay_in    = '0;
      case (mode_ff)
         mht_pkg::MODE_INSERT: begin
            wr_key        = 1'b1;
            wr_pay        = 1'b1;
            res_status_in = 1'b0;
            res_key_in    = key_rd_ff;
         end
         mht_pkg::MODE_LOOKUP: begin
            res_key_in = key_rd_ff;
            if (hit) begin
               res_status_in = 1'b0;
               res_pay_in    = pay_rd_ff;
            end
         end
         mht_pkg::MODE_REMOVE: begin
            res_key_in = key_rd_ff;
            if (hit) begin
               res_status_in = 1'b0;
               res_pay_in    = pay_rd_ff;
               wr_key        = 1'b1;
               wr_pay        = 1'b1;
               new_key       = '0;
               new_pay       = '0;
            end
         end
         mht_pkg::MODE_UPDATE: begin
            res_key_in = key_rd_ff;
            if (hit) begin
               res_status_in = 1'b0;
               res_pay_in    = pay_rd_ff;
               wr_pay        = 1'b1;
            end
         end
         mht_pkg::MODE_CLEAR: begin
            res_status_in = !any_ff;
         end
         default: begin
            res_status_in = 1'b1;
         end
      endcase
   end

   // stores: key store shares its port between sweep and operation
   logic [mht_pkg::KEY_W-1:0] slot_keys     [TABLE_DEPTH];
   logic [mht_pkg::PAY_W-1:0] slot_payloads [TABLE_DEPTH];
   logic [AW-1:0]             mem_addr;
   logic                      key_we, key_re, pay_we;
   logic [mht_pkg::KEY_W-1:0] key_wd;

   assign mem_addr = cmd.sweep ? sw_ff : slot;
   assign key_we   = cmd.sweep || (cmd.exec && wr_key);
   assign key_re   = cmd.sweep || cmd.mem_read;
   assign key_wd   = cmd.sweep ? '0 : new_key;
   assign pay_we   = cmd.exec && wr_pay;

   always_ff @(posedge clock) begin
      if (key_we) slot_keys[mem_addr] <= key_wd;
      if (key_re) key_rd_ff <= slot_keys[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (pay_we) slot_payloads[slot] <= new_pay;
      if (cmd.mem_read) pay_rd_ff <= slot_payloads[slot];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff       <= '0;
         sweep_rd_ff <= 1'b0;
      end else begin
         sw_ff       <= sw_in;
         sweep_rd_ff <= sweep_rd_in;
      end
   end

   // datapath registers without reset
   logic                      res_status_ff;
   logic [mht_pkg::KEY_W-1:0] res_key_ff;
   logic [mht_pkg::PAY_W-1:0] res_pay_ff;
   logic                      rsp_status_ff;
   logic [mht_pkg::KEY_W-1:0] rsp_key_ff;
   logic [mht_pkg::PAY_W-1:0] rsp_pay_ff;

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      any_ff <= any_in;
      if (cmd.latch) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
         pay_ff  <= req_payload;
      end
      if (cmd.exec) begin
         res_status_ff <= res_status_in;
         res_key_ff    <= res_key_in;
         res_pay_ff    <= res_pay_in;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_key_ff    <= res_key_ff;
         rsp_pay_ff    <= res_pay_ff;
      end
   end

   assign rsp_status  = rsp_status_ff;
   assign rsp_key     = rsp_key_ff;
   assign rsp_payload = rsp_pay_ff;

   assign stat.is_clear   = (mode_ff == mht_pkg::MODE_CLEAR);
   assign stat.div_last   = (cnt_ff == '0);
   assign stat.sweep_last = sweep_last;
   assign stat.init_last  = init_last;

endmodule
`default_nettype wire

// ===== rtl/core/modulo_hashed_record_table_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// modulo_hashed_record_table_top
// Direct-mapped record table, slot = key mod table size.
// ---------------------------------------------------------------------------
// Usage
//   req_*  : one command word per handshake; tuser carries the mode
//            (insert, lookup, remove, clear all, update payload).
//   rsp_*  : exactly one result word per command, in order; tuser is the
//            status (0 hit/success, 1 miss/empty), tdata the stored key
//            and the hit payload.
//   csr_*  : writes the table size; only write while the table is idle.
// Sequence
//   Keyed commands: key mod size, one key bit a cycle; read both stores;
//   apply the operation; load the result as req_tready rises. Clear all:
//   one slot below the size in use cleared a cycle on the single key-store
//   port. A stalled output delays req_tready to match.
// Reset
//   A clearing pass empties every slot of the table; req_tready
//   stays low until it ends. The size register returns to 1021.
// Back-pressure
//   A held result sits in the output register; the next command is still
//   taken and worked, then waits for the register to free up.
// ---------------------------------------------------------------------------
module modulo_hashed_record_table_top #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [mht_pkg::DATA_W-1:0]    req_tdata,   // key[30:0], payload[94:31], pad
   input  logic [mht_pkg::MODE_W-1:0]    req_tuser,   // mode[2:0]
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mht_pkg::DATA_W-1:0]    rsp_tdata,   // found_key[30:0], found_payload[94:31], pad
   output logic                          rsp_tuser,   // status
   // size register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mht_pkg::SIZE_W-1:0]    csr_data
);

   mht_pkg::cmd_type  cmd;
   mht_pkg::stat_type stat;

   // table size register, always writable
   logic [mht_pkg::SIZE_W-1:0] csr_size_ff, csr_size_in;

   assign csr_ready   = 1'b1;
   assign csr_size_in = (csr_valid && csr_ready) ? csr_data : csr_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_size_ff <= mht_pkg::SIZE_RESET;
      end else begin
         csr_size_ff <= csr_size_in;
      end
   end

   logic                       rsp_status;
   logic [mht_pkg::KEY_W-1:0]  rsp_key;
   logic [mht_pkg::PAY_W-1:0]  rsp_payload;

   mht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   mht_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_size    (csr_size_ff),
      .req_mode    (req_tuser),
      .req_key     (req_tdata[mht_pkg::KEY_W-1:0]),
      .req_payload (req_tdata[mht_pkg::KEY_W+mht_pkg::PAY_W-1:mht_pkg::KEY_W]),
      .rsp_status  (rsp_status),
      .rsp_key     (rsp_key),
      .rsp_payload (rsp_payload)
   );

   // pad bit above payload is zero
   assign rsp_tdata = {{(mht_pkg::DATA_W - mht_pkg::KEY_W - mht_pkg::PAY_W){1'b0}},
                       rsp_payload, rsp_key};
   assign rsp_tuser = rsp_status;

endmodule
`default_nettype wire

// ===== rtl/core/mht_chk.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mht_chk
// Port-level checks on the record table, bound to the top level.
// ---------------------------------------------------------------------------
`include "modulo_hashed_record_table_top_assert.svh"

module mht_chk (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [mht_pkg::DATA_W-1:0] rsp_tdata,
   input  logic                       rsp_tuser
);

   // a stalled result word holds
   `MHT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result word changed under stall")

   // one command in flight: ready drops after an accept
   `MHT_ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready, "request taken while busy")

   // a new result only at the end of work, never out of idle
   `MHT_ASSERT_NOW(a_rsp_after_work, $rose(rsp_tvalid), !$past(req_tready), "result without work")

endmodule

bind modulo_hashed_record_table_top mht_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
